// ===== src/dcd_pkg.sv =====
// Shared constants, types and codes for the deadlock cycle detector.
// No dependencies; deadlock_cycle_detector imports this package.
package dcd_pkg;

  // Graph size
  localparam int NUM_THREADS   = 8;
  localparam int NUM_RESOURCES = 8;

  // Event field widths
  localparam int CMD_W = 2;
  localparam int TID_W = 3;
  localparam int RID_W = 3;

  // Memory address widths
  localparam int THR_AW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int RES_AW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

  // Stream data widths, rounded up to whole bytes
  localparam int IN_BITS     = CMD_W + TID_W + RID_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic [NUM_THREADS-1:0]   thr_set_t;
  typedef logic [NUM_RESOURCES-1:0] res_set_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE    = 2'd0,
    CMD_RELEASE    = 2'd1,
    CMD_WAIT_BEGIN = 2'd2,
    CMD_WAIT_END   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN,
    ST_HELD,
    ST_WAITERS,
    ST_DONE
  } state_t;

endpackage

// ===== src/deadlock_cycle_detector.sv =====
// Top level of the deadlock cycle detector: resource allocation graph in two RAMs
// and a sequencer that searches for a cycle back to the waiting thread.
// Depends on dcd_pkg and dcd_ram.
//
//   channel | dir | tdata fields (low bit first)                        | tuser
//   in_     | in  | cmd[1:0], thread_id[4:2], resource_id[7:5]          | -
//   out_    | out | deadlock[0], zero fill [7:1]                        | -
//
// Acquire, release and wait_end beats are handled as read, write back, result.
// A wait_begin beat adds a search that reads each thread's hold word and each
// resource's waiter word at most once, each read issued in the scan state and
// used in the held or waiters state, plus one closing check.
// The result step waits while the output register holds an unaccepted beat.
// One beat is worked on at a time; a new beat is taken while out_tvalid waits.
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
module deadlock_cycle_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dcd_pkg::IN_TDATA_W-1:0] in_tdata,   // cmd, thread_id, resource_id
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dcd_pkg::OUT_TDATA_W-1:0] out_tdata  // deadlock
);

  import dcd_pkg::*;

  // Lowest set member of a thread set
  function automatic logic [THR_AW-1:0] first_thr(input thr_set_t s);
    logic [THR_AW-1:0] idx;
    idx = '0;
    for (int i = NUM_THREADS - 1; i >= 0; i--) begin
      if (s[i]) idx = THR_AW'(i);
    end
    return idx;
  endfunction

  // Lowest set member of a resource set
  function automatic logic [RES_AW-1:0] first_res(input res_set_t s);
    logic [RES_AW-1:0] idx;
    idx = '0;
    for (int i = NUM_RESOURCES - 1; i >= 0; i--) begin
      if (s[i]) idx = RES_AW'(i);
    end
    return idx;
  endfunction

  // Input field split
  logic [CMD_W-1:0] in_cmd;
  logic [TID_W-1:0] in_tid;
  logic [RID_W-1:0] in_rid;
  logic             in_ok;

  assign in_cmd = in_tdata[CMD_W-1:0];
  assign in_tid = in_tdata[CMD_W+TID_W-1:CMD_W];
  assign in_rid = in_tdata[CMD_W+TID_W+RID_W-1:CMD_W+TID_W];
  assign in_ok  = (32'(in_tid) < NUM_THREADS) && (32'(in_rid) < NUM_RESOURCES);

  // Control and working registers
  state_t            state_r,      state_nxt;
  cmd_t              cmd_r,        cmd_nxt;
  logic [THR_AW-1:0] tid_r,        tid_nxt;
  logic [RES_AW-1:0] rid_r,        rid_nxt;
  logic              ok_r,         ok_nxt;
  thr_set_t          pend_r,       pend_nxt;    // threads to expand
  thr_set_t          exp_r,        exp_nxt;     // threads already expanded
  res_set_t          res_r,        res_nxt;     // resources reached
  res_set_t          rdone_r,      rdone_nxt;   // resources already expanded
  thr_set_t          reach_r,      reach_nxt;   // threads reached in one step or more
  logic              dl_r,         dl_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic              out_dl_r,     out_dl_nxt;

  // Per-entry valid bits; an entry never written reads as empty
  thr_set_t          held_vld_r,   held_vld_nxt;
  res_set_t          wait_vld_r,   wait_vld_nxt;
  logic              hq_vld_r;
  logic              wq_vld_r;

  // RAM ports
  logic              held_we;
  logic [THR_AW-1:0] held_waddr;
  res_set_t          held_wdata;
  logic [THR_AW-1:0] held_raddr;
  res_set_t          held_rdata;
  logic              wait_we;
  logic [RES_AW-1:0] wait_waddr;
  thr_set_t          wait_wdata;
  logic [RES_AW-1:0] wait_raddr;
  thr_set_t          wait_rdata;

  res_set_t          held_q;
  thr_set_t          wait_q;
  thr_set_t          tbit;
  res_set_t          rbit;
  thr_set_t          todo_t;
  res_set_t          todo_r;
  logic [THR_AW-1:0] pick_t;
  logic [RES_AW-1:0] pick_r;

  // Hold edges: one word per thread, bit r = resource held
  dcd_ram #(.WIDTH(NUM_RESOURCES), .DEPTH(NUM_THREADS)) u_held_ram (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  // Wait edges: one word per resource, bit t = thread waiting
  dcd_ram #(.WIDTH(NUM_THREADS), .DEPTH(NUM_RESOURCES)) u_wait_ram (
    .clk   (clk),
    .we    (wait_we),
    .waddr (wait_waddr),
    .wdata (wait_wdata),
    .raddr (wait_raddr),
    .rdata (wait_rdata)
  );

  // Read data with unwritten entries forced empty
  assign held_q = held_rdata & {NUM_RESOURCES{hq_vld_r}};
  assign wait_q = wait_rdata & {NUM_THREADS{wq_vld_r}};

  assign tbit   = thr_set_t'(1) << tid_r;
  assign rbit   = res_set_t'(1) << rid_r;
  assign todo_t = pend_r & ~exp_r;
  assign todo_r = res_r & ~rdone_r;
  assign pick_t = first_thr(todo_t);
  assign pick_r = first_res(todo_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_dl_r};

  // Next state, RAM control and search step
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tid_nxt        = tid_r;
    rid_nxt        = rid_r;
    ok_nxt         = ok_r;
    pend_nxt       = pend_r;
    exp_nxt        = exp_r;
    res_nxt        = res_r;
    rdone_nxt      = rdone_r;
    reach_nxt      = reach_r;
    dl_nxt         = dl_r;
    out_dl_nxt     = out_dl_r;
    held_vld_nxt   = held_vld_r;
    wait_vld_nxt   = wait_vld_r;
    held_we        = 1'b0;
    held_waddr     = tid_r;
    held_wdata     = held_q;
    held_raddr     = THR_AW'(in_tid);
    wait_we        = 1'b0;
    wait_waddr     = rid_r;
    wait_wdata     = wait_q;
    wait_raddr     = RES_AW'(in_rid);

    // Output register drains on its handshake
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        // Both words of the event are read as the beat is taken
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          tid_nxt   = THR_AW'(in_tid);
          rid_nxt   = RES_AW'(in_rid);
          ok_nxt    = in_ok;
          state_nxt = ST_UPD;
        end
      end

      ST_UPD: begin
        // Modify and write back the edge word
        if (ok_r) begin
          case (cmd_r)
            CMD_ACQUIRE: begin
              held_we    = 1'b1;
              held_wdata = held_q | rbit;
            end
            CMD_RELEASE: begin
              held_we    = 1'b1;
              held_wdata = held_q & ~rbit;
            end
            CMD_WAIT_BEGIN: begin
              wait_we    = 1'b1;
              wait_wdata = wait_q | tbit;
            end
            CMD_WAIT_END: begin
              wait_we    = 1'b1;
              wait_wdata = wait_q & ~tbit;
            end
            default: begin
              held_we = 1'b0;
            end
          endcase
        end
        if (held_we) held_vld_nxt[tid_r] = 1'b1;
        if (wait_we) wait_vld_nxt[rid_r] = 1'b1;
        // Search starts from the requesting thread
        pend_nxt  = tbit;
        exp_nxt   = '0;
        res_nxt   = '0;
        rdone_nxt = '0;
        reach_nxt = '0;
        dl_nxt    = 1'b0;
        state_nxt = (ok_r && cmd_r == CMD_WAIT_BEGIN) ? ST_SCAN : ST_DONE;
      end

      ST_SCAN: begin
        // Threads first, then resources; stop once the thread is reached
        held_raddr = pick_t;
        wait_raddr = pick_r;
        if (reach_r[tid_r]) begin
          dl_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else if (todo_t != '0) begin
          exp_nxt[pick_t] = 1'b1;
          state_nxt       = ST_HELD;
        end else if (todo_r != '0) begin
          rdone_nxt[pick_r] = 1'b1;
          state_nxt         = ST_WAITERS;
        end else begin
          dl_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end
      end

      ST_HELD: begin
        res_nxt   = res_r | held_q;
        state_nxt = ST_SCAN;
      end

      ST_WAITERS: begin
        reach_nxt = reach_r | wait_q;
        pend_nxt  = pend_r | wait_q;
        state_nxt = ST_SCAN;
      end

      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_dl_nxt     = dl_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      held_vld_r   <= '0;
      wait_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      held_vld_r   <= held_vld_nxt;
      wait_vld_r   <= wait_vld_nxt;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    tid_r    <= tid_nxt;
    rid_r    <= rid_nxt;
    ok_r     <= ok_nxt;
    pend_r   <= pend_nxt;
    exp_r    <= exp_nxt;
    res_r    <= res_nxt;
    rdone_r  <= rdone_nxt;
    reach_r  <= reach_nxt;
    dl_r     <= dl_nxt;
    out_dl_r <= out_dl_nxt;
    hq_vld_r <= held_vld_r[held_raddr];
    wq_vld_r <= wait_vld_r[wait_raddr];
  end

endmodule

// ===== src/dcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
